[hw/rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// shared constants, types and text helpers for the servo command line parser
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned LineCapacity = 16;

  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam int unsigned OpenLen  = 9;
  localparam int unsigned CloseLen = 10;
  localparam int unsigned PrefLen  = 12;

  localparam logic [8*OpenLen-1:0]  TxtOpen  = "GATE OPEN";
  localparam logic [8*CloseLen-1:0] TxtClose = "GATE CLOSE";
  localparam logic [8*PrefLen-1:0]  TxtPref  = "SERVO ANGLE=";

  localparam logic [7:0]  MaxAngle = 8'd180;
  localparam logic [7:0]  MinAngle = 8'd0;
  localparam logic [10:0] MinPulse = 11'd1000;

  // angle * 1000 / 180 == (angle * 182050) >> 15 for every angle up to 180
  localparam logic [17:0] PulseRecip = 18'd182050;
  localparam int unsigned PulseShift = 15;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_DIRECT = 2'd2
  } kind_e;

  typedef struct packed {
    logic       hit;
    kind_e      kind;
    logic [7:0] angle;
  } result_t;

  function automatic logic [7:0] open_char(input logic [3:0] idx);
    return TxtOpen[8*(OpenLen-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] close_char(input logic [3:0] idx);
    return TxtClose[8*(CloseLen-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] pref_char(input logic [3:0] idx);
    return TxtPref[8*(PrefLen-1-int'(idx)) +: 8];
  endfunction

endpackage

[hw/rtl/scp_line_tracker.sv]
// ----------------------------------------------------------------------------
// scp_line_tracker
// follows the current line one byte at a time and matches the commands
// ----------------------------------------------------------------------------
module scp_line_tracker #(
  parameter int unsigned LineCapacity = scp_pkg::LineCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output scp_pkg::result_t  result_o
);
  import scp_pkg::*;

  localparam int unsigned LenW = $clog2(LineCapacity);

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] eff_q, eff_d;
  logic            zero_q, zero_d;
  logic            open_ok_q, open_ok_d;
  logic            close_ok_q, close_ok_d;
  logic            pref_ok_q, pref_ok_d;
  logic            dig_ok_q, dig_ok_d;
  logic [7:0]      val_q, val_d;

  logic            is_digit;
  logic [10:0]     next_val;
  logic            open_hit, close_hit, direct_hit;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign next_val = 11'(val_q) * 11'd10 + 11'(byte_i - ChZero);

  assign open_hit   = open_ok_q && (eff_q == LenW'(OpenLen));
  assign close_hit  = close_ok_q && (eff_q == LenW'(CloseLen));
  assign direct_hit = pref_ok_q && dig_ok_q && (eff_q > LenW'(PrefLen));

  always_comb begin
    result_o.hit   = (byte_i == ChLf) && (open_hit || close_hit || direct_hit);
    result_o.kind  = KIND_DIRECT;
    result_o.angle = val_q;
    if (open_hit) begin
      result_o.kind  = KIND_OPEN;
      result_o.angle = MaxAngle;
    end else if (close_hit) begin
      result_o.kind  = KIND_CLOSE;
      result_o.angle = MinAngle;
    end
  end

  always_comb begin
    len_d      = len_q;
    eff_d      = eff_q;
    zero_d     = zero_q;
    open_ok_d  = open_ok_q;
    close_ok_d = close_ok_q;
    pref_ok_d  = pref_ok_q;
    dig_ok_d   = dig_ok_q;
    val_d      = val_q;
    if (byte_i == ChCr) begin
      // ignored
    end else if ((byte_i == ChLf) || (len_q == LenW'(LineCapacity - 1))) begin
      len_d      = '0;
      eff_d      = '0;
      zero_d     = 1'b0;
      open_ok_d  = 1'b1;
      close_ok_d = 1'b1;
      pref_ok_d  = 1'b1;
      dig_ok_d   = 1'b1;
      val_d      = '0;
    end else begin
      len_d = len_q + 1'b1;
      if (!zero_q) begin
        if (byte_i == ChNul) begin
          zero_d = 1'b1;
        end else begin
          eff_d = eff_q + 1'b1;
          if (eff_q < LenW'(OpenLen)) begin
            open_ok_d = open_ok_q && (byte_i == open_char(eff_q[3:0]));
          end else begin
            open_ok_d = 1'b0;
          end
          if (eff_q < LenW'(CloseLen)) begin
            close_ok_d = close_ok_q && (byte_i == close_char(eff_q[3:0]));
          end else begin
            close_ok_d = 1'b0;
          end
          if (eff_q < LenW'(PrefLen)) begin
            pref_ok_d = pref_ok_q && (byte_i == pref_char(eff_q[3:0]));
          end else begin
            dig_ok_d = dig_ok_q && is_digit && (next_val <= 11'(MaxAngle));
            val_d    = next_val[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      eff_q      <= '0;
      zero_q     <= 1'b0;
      open_ok_q  <= 1'b1;
      close_ok_q <= 1'b1;
      pref_ok_q  <= 1'b1;
      dig_ok_q   <= 1'b1;
      val_q      <= '0;
    end else if (step_i) begin
      len_q      <= len_d;
      eff_q      <= eff_d;
      zero_q     <= zero_d;
      open_ok_q  <= open_ok_d;
      close_ok_q <= close_ok_d;
      pref_ok_q  <= pref_ok_d;
      dig_ok_q   <= dig_ok_d;
      val_q      <= val_d;
    end
  end

endmodule

[hw/rtl/servo_command_line_parser_core.sv]
// a line feed byte is held in the input register, then its result is held in the result register
// throughput: one byte per cycle while in_stall_o is low; the line state updates once per byte
// the input register stalls only while a held result is not taken
// reset: asynchronous, active low; clears the line and the valid bits of both pipeline registers
// ----------------------------------------------------------------------------
// servo_command_line_parser_core
// serial command line parser giving servo angle, pulse width and timer compare
// ----------------------------------------------------------------------------
module servo_command_line_parser_core #(
  parameter int unsigned LineCapacity = scp_pkg::LineCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scp_pkg::kind_e      command_kind_o,
  output logic [7:0]          angle_degrees_o,
  output logic [10:0]         pulse_micros_o,
  output logic [11:0]         compare_ticks_o
);
  import scp_pkg::*;

  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            out_free;
  logic            advance;
  result_t         result;
  logic [25:0]     pulse_prod;
  logic [10:0]     pulse_d;

  logic            out_valid_q;
  kind_e           kind_q;
  logic [7:0]      angle_q;
  logic [10:0]     pulse_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  scp_line_tracker #(
    .LineCapacity(LineCapacity)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (s1_byte_q),
    .result_o(result)
  );

  assign pulse_prod = 26'(result.angle) * 26'(PulseRecip);
  assign pulse_d    = MinPulse + 11'(pulse_prod >> PulseShift);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.hit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.hit) begin
      kind_q  <= result.kind;
      angle_q <= result.angle;
      pulse_q <= pulse_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_kind_o  = kind_q;
  assign angle_degrees_o = angle_q;
  assign pulse_micros_o  = pulse_q;
  assign compare_ticks_o = {pulse_q, 1'b0};

endmodule
